// ----- rtl/core/bofc_pkg.sv -----
// ----------------------------------------------------------------------------
// Bit offset field copy package
// Shared payload types, register indexes and position width for the core.
// ----------------------------------------------------------------------------
package bofc_pkg;

   // One source byte transfer.
   typedef struct packed {
      logic [7:0] source_byte;
      logic       final_byte;
   } req_type;

   // One destination byte transfer.
   typedef struct packed {
      logic [7:0] dest_byte;
      logic       final_result;
   } rsp_type;

   // Register indexes on the configuration port (word address).
   localparam logic [1:0] REG_SOURCE_BIT_START = 2'd0;
   localparam logic [1:0] REG_DEST_BIT_START   = 2'd1;
   localparam logic [1:0] REG_RUN_LENGTH_BITS  = 2'd2;

   // Width of bit position arithmetic: holds start + length + buffer size.
   localparam int POS_W = 11;

endpackage

// ----- rtl/core/bit_offset_field_copy_core.sv -----
// ----------------------------------------------------------------------------
// Bit offset field copy core
// Loads a source byte buffer, then builds the destination buffer one bit per
// cycle and emits it byte by byte, with the copied run at a bit offset.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                         Direction  Handshake
//  -------   ---------------------------   ---------  --------------------------
//  request   start, busy, req_data         in         start && !busy
//  response  rsp_valid, rsp_data           out        one-cycle strobe
//  config    psel, penable, pwrite, ...    in/out     APB, pready always high
//
// A non-final source byte leaves the core idle.
// After the final byte, the core is busy while it walks the destination bits
// and then drains; the datapath selects and shifts a single bit per cycle.
// A destination byte appears after every eighth bit, the last one in the first
// cycle in which busy is low.
// Reset is synchronous and clears control state and the configuration.
// The receiver cannot stall; results are never held.
module bit_offset_field_copy_core #(
   parameter int BUFFER_BYTES = 32
) (
   input  logic              clock,
   input  logic              reset,
   // Request channel
   input  logic              start,
   output logic              busy,
   input  bofc_pkg::req_type req_data,
   // Response channel
   output logic              rsp_valid,
   output bofc_pkg::rsp_type rsp_data,
   // Configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import bofc_pkg::*;

   localparam int AW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int CW    = $clog2(BUFFER_BYTES + 1);
   localparam int DW    = $clog2(8 * BUFFER_BYTES);
   localparam int BYTEW = POS_W - 3;

   typedef enum logic [1:0] {
      IDLE,
      COPY,
      DRAIN
   } state_type;

   state_type         state_ff;
   logic [DW-1:0]     dbit_ff;
   logic [CW-1:0]     load_count_ff;
   logic [7:0]        src_start_ff;
   logic [7:0]        dst_start_ff;
   logic [8:0]        run_len_ff;

   logic [7:0]        mem [BUFFER_BYTES];
   logic [7:0]        rd_data_ff;

   logic              pipe_vld_ff;
   logic              take_ff;
   logic [2:0]        src_sel_ff;
   logic [2:0]        dst_lo_ff;
   logic              last_ff;
   logic [6:0]        shift_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              accept;
   logic              cfg_write;
   logic              wr_en;
   logic [POS_W-1:0]  dpos;
   logic [POS_W-1:0]  koff;
   logic [POS_W-1:0]  spos;
   logic              take_in;
   logic [AW-1:0]     rd_addr;
   logic              bit_in;
   logic              dbit_last;

   assign busy      = (state_ff != IDLE);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign wr_en     = accept && (load_count_ff < CW'(BUFFER_BYTES));
   assign dbit_last = (dbit_ff == DW'(8 * BUFFER_BYTES - 1));

   // Register readback.
   always_comb begin
      prdata = '0;
      case (paddr[3:2])
         REG_SOURCE_BIT_START: prdata = {24'd0, src_start_ff};
         REG_DEST_BIT_START:   prdata = {24'd0, dst_start_ff};
         REG_RUN_LENGTH_BITS:  prdata = {23'd0, run_len_ff};
         default:              prdata = '0;
      endcase
   end

   // Map the current destination bit to its source bit and decide whether
   // it lies inside the run, inside the buffer and inside the loaded bytes.
   always_comb begin
      dpos    = POS_W'(dbit_ff);
      koff    = dpos - POS_W'(dst_start_ff);
      spos    = koff + POS_W'(src_start_ff);
      take_in = (dpos >= POS_W'(dst_start_ff))
             && (koff < POS_W'(run_len_ff))
             && (spos < POS_W'(8 * BUFFER_BYTES))
             && (spos[POS_W-1:3] < BYTEW'(load_count_ff));
      rd_addr = take_in ? spos[AW+2:3] : '0;
   end

   // Selected source bit, MSB first within its byte.
   assign bit_in = take_ff & rd_data_ff[~src_sel_ff];

   // Source buffer: written while loading, read one byte a cycle while copying.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[load_count_ff[AW-1:0]] <= req_data.source_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control, configuration, bit pipeline and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         dbit_ff       <= '0;
         load_count_ff <= '0;
         src_start_ff  <= '0;
         dst_start_ff  <= '0;
         run_len_ff    <= '0;
         pipe_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Configuration writes.
         if (cfg_write) begin
            case (paddr[3:2])
               REG_SOURCE_BIT_START: src_start_ff <= pwdata[7:0];
               REG_DEST_BIT_START:   dst_start_ff <= pwdata[7:0];
               REG_RUN_LENGTH_BITS:  run_len_ff   <= pwdata[8:0];
               default:              ;
            endcase
         end

         // Sequencer over the destination bits.
         case (state_ff)
            IDLE: begin
               if (wr_en) begin
                  load_count_ff <= load_count_ff + 1'b1;
               end
               if (accept && req_data.final_byte) begin
                  state_ff <= COPY;
                  dbit_ff  <= '0;
               end
            end
            COPY: begin
               if (dbit_last) begin
                  state_ff <= DRAIN;
               end else begin
                  dbit_ff <= dbit_ff + 1'b1;
               end
            end
            DRAIN: begin
               state_ff      <= IDLE;
               load_count_ff <= '0;
               dbit_ff       <= '0;
            end
            default: state_ff <= IDLE;
         endcase

         // First stage: memory read in flight with its bit select.
         pipe_vld_ff <= (state_ff == COPY);
         take_ff     <= take_in;
         src_sel_ff  <= spos[2:0];
         dst_lo_ff   <= dbit_ff[2:0];
         last_ff     <= dbit_last;

         // Second stage: shift the bit in, emit a byte every eighth bit.
         rsp_valid_ff <= 1'b0;
         if (pipe_vld_ff) begin
            shift_ff <= {shift_ff[5:0], bit_in};
            if (dst_lo_ff == 3'd7) begin
               rsp_valid_ff              <= 1'b1;
               rsp_data_ff.dest_byte     <= {shift_ff, bit_in};
               rsp_data_ff.final_result  <= last_ff;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result transfer only follows a cycle in which the copy was running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result transfer without a running copy");

   // The load count never passes the buffer size.
   assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= CW'(BUFFER_BYTES))
      else $error("load count overflow");

   // The final byte goes out with the core idle and the source store emptied.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_result |-> !busy && (load_count_ff == '0))
      else $error("final result while the job is still open");

   // Nothing is loaded while the copy walks the buffer.
   assert property (@(posedge clock) disable iff (reset)
      busy |=> $stable(load_count_ff) || (load_count_ff == '0))
      else $error("source loaded during copy");

endmodule

// ----- tb/sv/bofc_copy_checker.sv -----
// ----------------------------------------------------------------------------
// Bit offset field copy checker
// Watches the request, response and register ports of the core, keeps its own
// copy of the source buffer and registers, and compares every destination
// byte against the byte predicted for it.
// ----------------------------------------------------------------------------
module bofc_copy_checker #(
   parameter int BUFFER_BYTES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  bofc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  bofc_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                errors,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import bofc_pkg::*;

   localparam int BIT_COUNT = BUFFER_BYTES * 8;

   // Shadow of the core's source buffer and register file.
   logic [7:0]  source_bytes [BUFFER_BYTES];
   int unsigned load_count;
   logic [7:0]  source_start;
   logic [7:0]  dest_start;
   logic [8:0]  run_bits;

   // Destination bytes still owed by the core, oldest first.
   rsp_type     dest_bytes_q [$];
   int          byte_number;

   initial begin
      errors      = 0;
      outstanding = 0;
   end

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      errors = errors + 1;
   endtask

   // Build the destination buffer from the shadow source and registers and
   // queue every byte of it; the last one carries the final mark.
   task automatic queue_dest_buffer();
      logic [7:0] dest [BUFFER_BYTES];
      int         src_pos;
      int         dst_pos;
      rsp_type    item;
      foreach (dest[i]) dest[i] = 8'h00;
      for (int k = 0; k < int'(run_bits); k++) begin
         src_pos = int'(source_start) + k;
         dst_pos = int'(dest_start) + k;
         // Bits past either end of a buffer are dropped.
         if (src_pos < BIT_COUNT && dst_pos < BIT_COUNT) begin
            if (source_bytes[src_pos / 8][7 - src_pos % 8]) begin
               dest[dst_pos / 8][7 - dst_pos % 8] = 1'b1;
            end
         end
      end
      for (int i = 0; i < BUFFER_BYTES; i++) begin
         item.dest_byte    = dest[i];
         item.final_result = (i == BUFFER_BYTES - 1);
         dest_bytes_q.push_back(item);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         foreach (source_bytes[i]) source_bytes[i] = 8'h00;
         load_count   = 0;
         source_start = '0;
         dest_start   = '0;
         run_bits     = '0;
         byte_number  = 0;
         dest_bytes_q.delete();
         outstanding <= 0;
      end else begin
         // Register writes complete in the access phase.
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_SOURCE_BIT_START: source_start = pwdata[7:0];
               REG_DEST_BIT_START:   dest_start   = pwdata[7:0];
               REG_RUN_LENGTH_BITS:  run_bits     = pwdata[8:0];
               default: ;
            endcase
         end

         // Each response transfer is matched against the oldest prediction.
         if (rsp_valid) begin
            if (dest_bytes_q.size() == 0) begin
               report_mismatch($sformatf("destination byte 0x%02h with none expected",
                                         rsp_data.dest_byte));
            end else begin
               want = dest_bytes_q.pop_front();
               if (rsp_data.dest_byte !== want.dest_byte) begin
                  report_mismatch($sformatf("byte %0d: dest_byte 0x%02h, expected 0x%02h",
                                            byte_number, rsp_data.dest_byte,
                                            want.dest_byte));
               end
               if (rsp_data.final_result !== want.final_result) begin
                  report_mismatch($sformatf("byte %0d: final_result %b, expected %b",
                                            byte_number, rsp_data.final_result,
                                            want.final_result));
               end
               byte_number = want.final_result ? 0 : byte_number + 1;
            end
         end

         // A request transfer loads one source byte; once the buffer is full
         // further bytes are dropped, but a final mark still starts the copy.
         if (start && !busy) begin
            if (load_count < BUFFER_BYTES) begin
               source_bytes[load_count] = req_data.source_byte;
               load_count = load_count + 1;
            end
            if (req_data.final_byte) begin
               queue_dest_buffer();
               foreach (source_bytes[i]) source_bytes[i] = 8'h00;
               load_count = 0;
            end
         end

         outstanding <= dest_bytes_q.size();
      end
   end

endmodule

// ----- tb/sv/bit_offset_field_copy_core_test.sv -----
// ----------------------------------------------------------------------------
// Bit offset field copy core test
// Drives source byte jobs and register settings into the core, from a short
// directed set of corner cases into randomized jobs under varying sender gaps,
// and leaves the byte-level comparison to the checker beside the core.
// ----------------------------------------------------------------------------
module bit_offset_field_copy_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bofc_pkg::*;

   localparam int BUFFER_BYTES   = 32;
   localparam int DIRECTED_ITEMS = 12;
   localparam int RANDOM_ITEMS   = 130;
   localparam int SETTLE_CYCLES  = 4;
   localparam int CYCLE_LIMIT    = 300000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int          errors;
   int          outstanding;
   int          sent_items;
   int          idle_pct;
   int          cycle_count;

   bit_offset_field_copy_core #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   bofc_copy_checker #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) copy_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .errors      (errors),
      .outstanding (outstanding)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Guard against a hung run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // One register write: setup cycle, then access until pready. The select
   // stays up so that back-to-back writes need no extra edge.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   // Program all three registers, then release the port.
   task automatic set_copy_window(input logic [7:0] src, input logic [7:0] dst,
                                  input logic [8:0] len);
      csr_write(REG_SOURCE_BIT_START, {24'h0, src});
      csr_write(REG_DEST_BIT_START, {24'h0, dst});
      csr_write(REG_RUN_LENGTH_BITS, {23'h0, len});
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one source byte, with a random gap first, and hold it until the
   // transfer completes. start is left high for a possible next byte.
   task automatic send_byte(input logic [7:0] value, input logic last);
      idle_pct = (sent_items < 50) ? 20 : (sent_items < 100) ? 86 : 0;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{source_byte: value, final_byte: last};
      do @(posedge clock); while (busy);
      sent_items++;
   endtask

   // After the final byte, wait for every destination byte and let the core
   // settle before the registers may change again.
   task automatic finish_job();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A random job: mostly short buffers, sometimes one that overflows, with
   // windows that mostly start inside the loaded bits.
   task automatic run_random_job();
      int         nbytes;
      int         roll;
      logic [7:0] src;
      logic [7:0] dst;
      logic [8:0] len;
      logic [7:0] value;
      nbytes = ($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 36))
                                           : int'($urandom_range(1, 8));
      roll = int'($urandom_range(0, 99));
      if (roll < 15) src = 8'd0;
      else if (roll < 25) src = 8'd255;
      else src = 8'($urandom_range(0, (nbytes * 8 > 256) ? 255 : nbytes * 8 - 1));
      roll = int'($urandom_range(0, 99));
      if (roll < 10) dst = 8'd0;
      else if (roll < 20) dst = 8'd255;
      else dst = 8'($urandom_range(0, 255));
      roll = int'($urandom_range(0, 99));
      if (roll < 10) len = 9'd0;
      else if (roll < 20) len = 9'd256;
      else if (roll < 40) len = 9'($urandom_range(0, 256));
      else len = 9'($urandom_range(1, 64));
      set_copy_window(src, dst, len);
      for (int i = 0; i < nbytes; i++) begin
         roll = int'($urandom_range(0, 9));
         value = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom_range(0, 255));
         send_byte(value, i == nbytes - 1);
      end
      finish_job();
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      sent_items = 0;
      idle_pct   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at their reset values: a zero-length run gives all zeros.
      send_byte(8'hFF, 1'b1);
      finish_job();

      // Whole-buffer copy in place; unloaded positions read as zero.
      set_copy_window(8'd0, 8'd0, 9'd256);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      finish_job();

      // Both starts at the last bit with the longest run.
      set_copy_window(8'd255, 8'd255, 9'd256);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      finish_job();

      // Run that spills past the end of the destination.
      set_copy_window(8'd3, 8'd250, 9'd20);
      send_byte(8'h1F, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hC3, 1'b1);
      finish_job();

      // Single-bit copy across a byte boundary.
      set_copy_window(8'd5, 8'd9, 9'd1);
      send_byte(8'h04, 1'b0);
      send_byte(8'h00, 1'b1);
      finish_job();

      // Randomized jobs through the three sender gap phases.
      while (sent_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         run_random_job();
      end

      repeat (16) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- bit_offset_field_copy_core.f -----
rtl/core/bofc_pkg.sv
rtl/core/bit_offset_field_copy_core.sv
tb/sv/bofc_copy_checker.sv
tb/sv/bit_offset_field_copy_core_test.sv
